@@ rtl/spn_pkg.sv @@
// ----------------------------------------------------------------------------
// SPN cipher package
// Word type, S-box tables, bit transposition and round key selection shared
// by the round stages of the 16-bit substitution-permutation cipher.
// ----------------------------------------------------------------------------
package spn_pkg;

    localparam int unsigned BlockWidth  = 16;
    localparam int unsigned KeyWidth    = 32;
    localparam int unsigned NibbleWidth = 4;
    localparam int unsigned NumRounds   = 4;

    typedef logic [BlockWidth-1:0]  block_t;
    typedef logic [KeyWidth-1:0]    key_t;
    typedef logic [NibbleWidth-1:0] nibble_t;
    typedef logic [1:0]             round_idx_t;

    typedef enum logic
    {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t    operation;
        key_t   cipher_key;
        block_t data_block;
    } spn_word_t;

    localparam round_idx_t LastRound = 2'd3;

    function automatic nibble_t sbox_fwd(input nibble_t x);
        nibble_t y;
        case (x)
            4'h0: y = 4'he;
            4'h1: y = 4'h4;
            4'h2: y = 4'hd;
            4'h3: y = 4'h1;
            4'h4: y = 4'h2;
            4'h5: y = 4'hf;
            4'h6: y = 4'hb;
            4'h7: y = 4'h8;
            4'h8: y = 4'h3;
            4'h9: y = 4'ha;
            4'ha: y = 4'h6;
            4'hb: y = 4'hc;
            4'hc: y = 4'h5;
            4'hd: y = 4'h9;
            4'he: y = 4'h0;
            default: y = 4'h7;
        endcase
        return y;
    endfunction

    function automatic nibble_t sbox_inv(input nibble_t x);
        nibble_t y;
        case (x)
            4'h0: y = 4'he;
            4'h1: y = 4'h3;
            4'h2: y = 4'h4;
            4'h3: y = 4'h8;
            4'h4: y = 4'h1;
            4'h5: y = 4'hc;
            4'h6: y = 4'ha;
            4'h7: y = 4'hf;
            4'h8: y = 4'h7;
            4'h9: y = 4'hd;
            4'ha: y = 4'h9;
            4'hb: y = 4'h6;
            4'hc: y = 4'hb;
            4'hd: y = 4'h2;
            4'he: y = 4'h0;
            default: y = 4'h5;
        endcase
        return y;
    endfunction

    function automatic block_t substitute_fwd(input block_t x);
        block_t y;
        for (int i = 0; i < 4; i++) begin
            y[i*4 +: 4] = sbox_fwd(x[i*4 +: 4]);
        end
        return y;
    endfunction

    function automatic block_t substitute_inv(input block_t x);
        block_t y;
        for (int i = 0; i < 4; i++) begin
            y[i*4 +: 4] = sbox_inv(x[i*4 +: 4]);
        end
        return y;
    endfunction

    // Bit 4a+b moves to bit 4b+a; the map is its own inverse.
    function automatic block_t transpose(input block_t x);
        block_t y;
        for (int a = 0; a < 4; a++) begin
            for (int b = 0; b < 4; b++) begin
                y[4*b + a] = x[4*a + b];
            end
        end
        return y;
    endfunction

    function automatic block_t round_key(input key_t key, input round_idx_t r);
        block_t k;
        case (r)
            2'd0: k = key[31:16];
            2'd1: k = key[27:12];
            2'd2: k = key[23:8];
            default: k = key[19:4];
        endcase
        return k;
    endfunction

endpackage

@@ rtl/spn_if.sv @@
// ----------------------------------------------------------------------------
// SPN cipher channels
// Valid/ready channels for the request and response words of the cipher.
// ----------------------------------------------------------------------------
interface spn_req_if;
    import spn_pkg::*;

    logic   valid;
    logic   ready;
    op_t    operation;
    key_t   cipher_key;
    block_t data_block;

    modport source (output valid, output operation, output cipher_key,
                    output data_block, input ready);
    modport sink   (input valid, input operation, input cipher_key,
                    input data_block, output ready);
endinterface

interface spn_rsp_if;
    import spn_pkg::*;

    logic   valid;
    logic   ready;
    block_t result_block;

    modport source (output valid, output result_block, input ready);
    modport sink   (input valid, input result_block, output ready);
endinterface

@@ rtl/spn_block_cipher_16bit.sv @@
// ----------------------------------------------------------------------------
// 16-bit SPN block cipher
// Four-round substitution-permutation cipher with a 32-bit key, one round
// per pipeline stage, encrypting or decrypting each word on its own.
// ----------------------------------------------------------------------------
// The cipher takes one request word per clock unless a response stall has
// backed up to the first stage, and carries each word through one register
// stage per cipher round; the last stage register drives the response channel
// directly. Encrypt and decrypt words may be mixed freely, and a stall on the
// response side holds the words backed up behind it in place while later
// words move up into empty stages, so request ready follows the occupancy of
// the stages.
module spn_block_cipher_16bit
    import spn_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    spn_req_if.sink   req,
    spn_rsp_if.source rsp
);

    logic      stage_valid [NumRounds+1];
    logic      stage_ready [NumRounds+1];
    spn_word_t stage_word  [NumRounds+1];

    assign stage_valid[0]          = req.valid;
    assign stage_word[0].operation  = req.operation;
    assign stage_word[0].cipher_key = req.cipher_key;
    assign stage_word[0].data_block = req.data_block;
    assign req.ready               = stage_ready[0];

    for (genvar g = 0; g < NumRounds; g++)
    begin : g_round
        spn_round_stage u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .round_idx (round_idx_t'(g)),
            .up_valid  (stage_valid[g]),
            .up_ready  (stage_ready[g]),
            .up_word   (stage_word[g]),
            .dn_valid  (stage_valid[g+1]),
            .dn_ready  (stage_ready[g+1]),
            .dn_word   (stage_word[g+1])
        );
    end

    assign stage_ready[NumRounds] = rsp.ready;
    assign rsp.valid              = stage_valid[NumRounds];
    assign rsp.result_block       = stage_word[NumRounds].data_block;

endmodule

@@ rtl/spn_round_stage.sv @@
// ----------------------------------------------------------------------------
// SPN round stage
// One registered pipeline stage: encryption round round_idx or decryption
// round three minus round_idx, chosen per word by its operation.
// ----------------------------------------------------------------------------
module spn_round_stage
    import spn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  round_idx_t round_idx,
    input  logic       up_valid,
    output logic       up_ready,
    input  spn_word_t  up_word,
    output logic       dn_valid,
    input  logic       dn_ready,
    output spn_word_t  dn_word
);

    logic       valid_reg;
    logic       valid_next;
    spn_word_t  word_reg;
    spn_word_t  word_next;
    round_idx_t dec_idx;
    block_t     whiten_key;
    block_t     enc_sub;
    block_t     enc_out;
    block_t     dec_pre;
    block_t     dec_out;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

    always_comb
    begin
        dec_idx    = LastRound - round_idx;
        whiten_key = up_word.cipher_key[15:0];
        enc_sub    = substitute_fwd(up_word.data_block ^
                                    round_key(up_word.cipher_key, round_idx));
        enc_out    = (round_idx == LastRound) ? (enc_sub ^ whiten_key)
                                              : transpose(enc_sub);
        dec_pre    = (dec_idx == LastRound) ? (up_word.data_block ^ whiten_key)
                                            : transpose(up_word.data_block);
        dec_out    = substitute_inv(dec_pre) ^ round_key(up_word.cipher_key, dec_idx);

        word_next            = up_word;
        word_next.data_block = (up_word.operation == OP_DECRYPT) ? dec_out : enc_out;
        valid_next           = up_ready ? up_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            word_reg <= word_next;
        end
    end

endmodule

@@ rtl/spn_checker.sv @@
// ----------------------------------------------------------------------------
// SPN cipher port checker
// Watches the request and response channels of the cipher for occupancy,
// latency and stall behavior.
// ----------------------------------------------------------------------------
module spn_checker
    import spn_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   req_valid,
    input logic   req_ready,
    input logic   rsp_valid,
    input logic   rsp_ready,
    input block_t rsp_result_block
);

    logic       req_fire;
    logic       rsp_fire;
    logic [2:0] count_reg;
    logic [2:0] count_next;

    assign req_fire = req_valid && req_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    always_comb
    begin
        count_next = count_reg + 3'(req_fire) - 3'(rsp_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 3'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    a_occupancy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'd4)
        else $error("more words in flight than pipeline stages");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> count_reg != 3'd0)
        else $error("response word without a pending request");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 3'd0 |-> req_ready)
        else $error("empty pipeline refuses a request");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(req_fire, 4) && $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3)
         && $past(rsp_ready, 1) && $past(rsp_ready, 2) && $past(rsp_ready, 3))
        |-> rsp_valid)
        else $error("word did not reach the response after four cycles");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_block))
        else $error("stalled response word changed");

endmodule

bind spn_block_cipher_16bit spn_checker u_spn_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_result_block (rsp.result_block)
);
